// ----- rtl/pixel_format_packer_macros.svh -----
// Assertion macros shared by the pixel format packer RTL.
// Depends on nothing; files that assert include it by bare name.
`ifndef PIXEL_FORMAT_PACKER_MACROS_SVH
`define PIXEL_FORMAT_PACKER_MACROS_SVH

// Same-cycle implication, checked on clk, quiet while arst_n is low.
`define PFP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, quiet while arst_n is low.
`define PFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pfp_pkg.sv -----
// Types, codes and the channel conversion function of the pixel format packer.
// No dependencies.
package pfp_pkg;

	localparam int PIXEL_W = 32;
	localparam int CFG_W   = 5;
	localparam int ADDR_W  = 3;

	localparam logic [ADDR_W-1:0] REG_CONVERT_ENABLE  = 3'd0;
	localparam logic [ADDR_W-1:0] REG_BYTES_PER_PIXEL = 3'd1;
	localparam logic [ADDR_W-1:0] REG_RED_BITS        = 3'd2;
	localparam logic [ADDR_W-1:0] REG_RED_POS         = 3'd3;
	localparam logic [ADDR_W-1:0] REG_GREEN_BITS      = 3'd4;
	localparam logic [ADDR_W-1:0] REG_GREEN_POS       = 3'd5;
	localparam logic [ADDR_W-1:0] REG_BLUE_BITS       = 3'd6;
	localparam logic [ADDR_W-1:0] REG_BLUE_POS        = 3'd7;

	typedef enum logic [1:0] {
		MODE_COPY,
		MODE_PACK24,
		MODE_PACK16
	} mode_t;

	// One entry of the packing state memory.
	typedef struct packed {
		logic [1:0]         phase;
		logic [PIXEL_W-1:0] carry;
	} state_t;

	// Access request to the state memory.
	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} ram_req_t;

	// ((c << bits) >> 8) << pos, taken to 32 bits.
	function automatic logic [PIXEL_W-1:0] chan_term(
		input logic [7:0] c,
		input logic [3:0] bits,
		input logic [4:0] pos
	);
		logic [22:0] sh;
		logic [14:0] v;
		sh = {15'b0, c} << bits;
		v  = sh[22:8];
		return {17'b0, v} << pos;
	endfunction

endpackage

// ----- rtl/pixel_format_packer.sv -----
// Pixel format packer top level: xRGB pixels in, packed frame-buffer words out.
// Depends on pfp_pkg, pfp_state_ram and pixel_format_packer_macros.svh.
//
// Accepts one 32-bit xRGB pixel per clock while out_ready keeps up, and emits
// words for a little-endian frame buffer: one word per pixel in 4-byte mode,
// three words per four pixels in 3-byte mode, one word per pixel pair in
// 2-byte mode. A word passes through stage 1 and the output register after
// the pixel that completes it is accepted; pixels that only start a word
// produce nothing. The rate is set by the read-modify-write of the packing
// state (phase and carried bits), which lives in a one-entry memory with a
// registered read: the read is issued when a pixel is accepted, the update
// is written when the pixel leaves the compute stage, and a write landing on
// the same edge as the next read is forwarded around the memory. The output
// register lets the next pixel enter while a finished word still waits for
// out_ready. Any configuration write drops a partly filled group; write
// configuration only while no pixel is in flight.
module pixel_format_packer
	import pfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PIXEL_W-1:0] source_pixel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIXEL_W-1:0] out_word
);

`include "pixel_format_packer_macros.svh"

	// ---------------- configuration registers ----------------
	logic       convert_enable_q;
	logic [2:0] bytes_per_pixel_q;
	logic [3:0] red_bits_q, green_bits_q, blue_bits_q;
	logic [4:0] red_pos_q, green_pos_q, blue_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			convert_enable_q  <= 1'b0;
			bytes_per_pixel_q <= 3'd4;
			red_bits_q        <= 4'd8;
			red_pos_q         <= 5'd16;
			green_bits_q      <= 4'd8;
			green_pos_q       <= 5'd8;
			blue_bits_q       <= 4'd8;
			blue_pos_q        <= 5'd0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_CONVERT_ENABLE:  convert_enable_q  <= cfg_wdata[0];
				REG_BYTES_PER_PIXEL: bytes_per_pixel_q <= cfg_wdata[2:0];
				REG_RED_BITS:        red_bits_q        <= cfg_wdata[3:0];
				REG_RED_POS:         red_pos_q         <= cfg_wdata[4:0];
				REG_GREEN_BITS:      green_bits_q      <= cfg_wdata[3:0];
				REG_GREEN_POS:       green_pos_q       <= cfg_wdata[4:0];
				REG_BLUE_BITS:       blue_bits_q       <= cfg_wdata[3:0];
				REG_BLUE_POS:        blue_pos_q        <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	// Output mode follows the register pair; raw mode never packs to 16 bits.
	mode_t mode;
	always_comb begin
		if (!convert_enable_q) begin
			mode = (bytes_per_pixel_q > 3'd3) ? MODE_COPY : MODE_PACK24;
		end else if (bytes_per_pixel_q == 3'd4) begin
			mode = MODE_COPY;
		end else if (bytes_per_pixel_q == 3'd3) begin
			mode = MODE_PACK24;
		end else begin
			mode = MODE_PACK16;
		end
	end

	// ---------------- handshake and stage 1 ----------------
	logic               in_accept;
	logic               s1_fire;
	logic               s1_valid_q;
	logic [PIXEL_W-1:0] pixel_s1;
	logic               fwd_sel_s1;
	state_t             fwd_state_s1;
	logic               out_valid_q;
	logic [PIXEL_W-1:0] out_word_q;

	ram_req_t ram_req;
	state_t   ram_rd_state;
	state_t   state_s1;
	state_t   next_state_s1;
	logic     state_wr_s1;
	logic     emit_s1;
	logic [PIXEL_W-1:0] word_s1;

	assign in_ready  = !s1_valid_q || s1_fire;
	assign in_accept = in_valid && in_ready;
	// Advance stage 1 when it makes no word, or the output slot is free or draining.
	assign s1_fire   = s1_valid_q && (!emit_s1 || !out_valid_q || out_ready);

	assign ram_req.rd  = in_accept;
	assign ram_req.wr  = s1_fire && state_wr_s1;
	assign ram_req.clr = cfg_wr_en;

	pfp_state_ram u_state_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.wr_data (next_state_s1),
		.rd_data (ram_rd_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Capture the pixel; when the leaving pixel writes state on the same edge,
	// the memory read sees the old entry, so hold the new value for forwarding.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			pixel_s1     <= source_pixel;
			fwd_sel_s1   <= ram_req.wr;
			fwd_state_s1 <= next_state_s1;
		end
	end

	assign state_s1 = fwd_sel_s1 ? fwd_state_s1 : ram_rd_state;

	// Channel conversion: blue 7-0, green 15-8, red 23-16.
	logic [PIXEL_W-1:0] conv_s1;
	logic [PIXEL_W-1:0] px_s1;
	assign conv_s1 = chan_term(pixel_s1[7:0],   blue_bits_q,  blue_pos_q)
	               | chan_term(pixel_s1[15:8],  green_bits_q, green_pos_q)
	               | chan_term(pixel_s1[23:16], red_bits_q,   red_pos_q);

	always_comb begin
		if (mode == MODE_PACK16) begin
			px_s1 = {16'b0, conv_s1[15:0]};
		end else if (convert_enable_q) begin
			px_s1 = conv_s1;
		end else begin
			px_s1 = pixel_s1;
		end
	end

	// Packing: merge the pixel with the carried bits and update the state.
	always_comb begin
		emit_s1       = 1'b1;
		word_s1       = px_s1;
		state_wr_s1   = 1'b0;
		next_state_s1 = state_s1;
		case (mode)
			MODE_COPY: begin
				emit_s1 = 1'b1;
			end
			MODE_PACK24: begin
				state_wr_s1 = 1'b1;
				case (state_s1.phase)
					2'd0: begin
						emit_s1             = 1'b0;
						next_state_s1.carry = px_s1;
						next_state_s1.phase = 2'd1;
					end
					2'd1: begin
						word_s1             = state_s1.carry | (px_s1 << 24);
						next_state_s1.carry = px_s1 >> 8;
						next_state_s1.phase = 2'd2;
					end
					2'd2: begin
						word_s1             = state_s1.carry | (px_s1 << 16);
						next_state_s1.carry = px_s1 >> 16;
						next_state_s1.phase = 2'd3;
					end
					default: begin
						word_s1             = state_s1.carry | (px_s1 << 8);
						next_state_s1.carry = '0;
						next_state_s1.phase = 2'd0;
					end
				endcase
			end
			MODE_PACK16: begin
				state_wr_s1 = 1'b1;
				if (!state_s1.phase[0]) begin
					emit_s1             = 1'b0;
					next_state_s1.carry = px_s1;
					next_state_s1.phase = 2'd1;
				end else begin
					word_s1             = state_s1.carry | (px_s1 << 16);
					next_state_s1.carry = '0;
					next_state_s1.phase = 2'd0;
				end
			end
			default: begin
				emit_s1 = 1'b1;
			end
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit_s1) begin
			out_word_q <= word_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// ---------------- assertions ----------------
	`PFP_ASSERT_NOW(a_no_overwrite, s1_fire && emit_s1, !out_valid_q || out_ready,
		"stage 1 overwrote a word still waiting at the output")
	`PFP_ASSERT_NOW(a_copy_no_state, s1_fire && mode == MODE_COPY, !ram_req.wr,
		"copy mode wrote packing state")
	`PFP_ASSERT_NEXT(a_fwd_taken, in_accept && ram_req.wr, fwd_sel_s1,
		"state write on the read edge was not forwarded")
	`PFP_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_fire,
		s1_valid_q && $stable(pixel_s1) && $stable(fwd_sel_s1),
		"stalled stage 1 lost its pixel")

endmodule

// ----- rtl/pfp_state_ram.sv -----
// Single-entry synchronous state memory of the pixel format packer, registered read.
// Depends on pfp_pkg; an entry reads as zero until written after a clear.
module pfp_state_ram
	import pfp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  ram_req_t req,
	input  state_t   wr_data,
	output state_t   rd_data
);

	state_t mem_q [1];
	state_t rd_data_q;
	logic   valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req.clr) begin
			valid_q <= 1'b0;
		end else if (req.wr) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_q[0] <= wr_data;
		end
		if (req.rd) begin
			rd_data_q <= valid_q ? mem_q[0] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- dv/tb.sv -----
// Testbench for pixel_format_packer: directed and random pixel streams with
// register writes between phases, checked word by word against a local predictor.
// Depends on pfp_pkg and the pixel_format_packer RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pfp_pkg::*;

	// Cycles without any accepted pixel or word before the run is declared hung.
	localparam int HANG_LIMIT = 1000;
	// Extra edges to wait out a pixel still in flight, with margin.
	localparam int FLUSH_CYCLES = 4;
	localparam int RANDOM_PIXELS = 1700;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [ADDR_W-1:0]  cfg_addr;
	logic [CFG_W-1:0]   cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [PIXEL_W-1:0] source_pixel;
	logic               out_valid;
	logic               out_ready;
	logic [PIXEL_W-1:0] out_word;

	pixel_format_packer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.source_pixel (source_pixel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_word     (out_word)
	);

	// Predictor copy of the register file, at the widths the block decodes.
	logic       cfg_convert;
	logic [2:0] cfg_bpp;
	logic [3:0] cfg_red_bits, cfg_green_bits, cfg_blue_bits;
	logic [4:0] cfg_red_pos, cfg_green_pos, cfg_blue_pos;

	// Predictor copy of the packing state.
	logic [1:0]  group_phase;
	logic [31:0] carry_bits;

	// Words the block owes us, oldest first.
	logic [31:0] expected_words[$];

	int  mismatch_count;
	int  idle_cycles;
	// Set for a phase to run both sides without any gaps.
	bit  no_idle;

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// One channel term: ((c << bits) >> 8) << pos, kept to 32 bits.
	function automatic logic [31:0] channel_field(input logic [7:0] c, input logic [3:0] bits,
			input logic [4:0] pos);
		logic [31:0] v;
		v = ({24'b0, c} << bits) >> 8;
		return v << pos;
	endfunction

	// Build the converted pixel; narrow trims every term to 16 bits first.
	function automatic logic [31:0] convert_pixel(input logic [31:0] px, input bit narrow);
		logic [31:0] b, g, r;
		b = channel_field(px[7:0], cfg_blue_bits, cfg_blue_pos);
		g = channel_field(px[15:8], cfg_green_bits, cfg_green_pos);
		r = channel_field(px[23:16], cfg_red_bits, cfg_red_pos);
		if (narrow) begin
			b = {16'b0, b[15:0]};
			g = {16'b0, g[15:0]};
			r = {16'b0, r[15:0]};
		end
		return b | g | r;
	endfunction

	// Three-byte packing: four pixels fill three words, overlaps are ORed.
	task automatic pack_three(input logic [31:0] p);
		case (group_phase)
			2'd0: begin
				carry_bits = p;
				group_phase = 2'd1;
			end
			2'd1: begin
				expected_words.push_back(carry_bits | (p << 24));
				carry_bits = p >> 8;
				group_phase = 2'd2;
			end
			2'd2: begin
				expected_words.push_back(carry_bits | (p << 16));
				carry_bits = p >> 16;
				group_phase = 2'd3;
			end
			default: begin
				expected_words.push_back(carry_bits | (p << 8));
				carry_bits = '0;
				group_phase = 2'd0;
			end
		endcase
	endtask

	// Advance the predictor by one accepted pixel and queue any finished word.
	task automatic pack_pixel(input logic [31:0] px);
		logic [31:0] p;
		if (!cfg_convert) begin
			// Raw: anything above 3 copies, everything else packs three-byte.
			if (cfg_bpp > 3'd3)
				expected_words.push_back(px);
			else
				pack_three(px);
		end else if (cfg_bpp == 3'd4) begin
			expected_words.push_back(convert_pixel(px, 1'b0));
		end else if (cfg_bpp == 3'd3) begin
			pack_three(convert_pixel(px, 1'b0));
		end else begin
			// Two-byte packing; only the low phase bit counts here.
			p = convert_pixel(px, 1'b1);
			if (!group_phase[0]) begin
				carry_bits = p;
				group_phase = 2'd1;
			end else begin
				expected_words.push_back(carry_bits | (p << 16));
				carry_bits = '0;
				group_phase = 2'd0;
			end
		end
	endtask

	// Offer one pixel after a random gap and hold it until accepted.
	task automatic send_pixel(input logic [31:0] px);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		source_pixel <= px;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pack_pixel(px);
	endtask

	// Drop valid, wait for every owed word, then let any word-less pixel drain.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	// Drive one register write and mirror it; the block clears its group on any write.
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		case (addr)
			REG_CONVERT_ENABLE:  cfg_convert    = data[0];
			REG_BYTES_PER_PIXEL: cfg_bpp        = data[2:0];
			REG_RED_BITS:        cfg_red_bits   = data[3:0];
			REG_RED_POS:         cfg_red_pos    = data[4:0];
			REG_GREEN_BITS:      cfg_green_bits = data[3:0];
			REG_GREEN_POS:       cfg_green_pos  = data[4:0];
			REG_BLUE_BITS:       cfg_blue_bits  = data[3:0];
			REG_BLUE_POS:        cfg_blue_pos   = data[4:0];
			default: ;
		endcase
		group_phase = 2'd0;
		carry_bits  = '0;
		@(posedge clk);
	endtask

	// Rewrite the whole register file once the block is idle.
	task automatic apply_config(input logic [CFG_W-1:0] conv, bpp, rbits, rpos, gbits, gpos,
			bbits, bpos);
		settle();
		write_reg(REG_CONVERT_ENABLE, conv);
		write_reg(REG_BYTES_PER_PIXEL, bpp);
		write_reg(REG_RED_BITS, rbits);
		write_reg(REG_RED_POS, rpos);
		write_reg(REG_GREEN_BITS, gbits);
		write_reg(REG_GREEN_POS, gpos);
		write_reg(REG_BLUE_BITS, bbits);
		write_reg(REG_BLUE_POS, bpos);
		cfg_wr_en <= 1'b0;
	endtask

	// Channel width word: mostly 0..8, sometimes the wider 9..15, random spare bit.
	function automatic logic [CFG_W-1:0] rand_bits_word();
		logic [3:0] v;
		v = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		return {1'($urandom_range(0, 1)), v};
	endfunction

	// Pixels: mostly random, with all-zero, all-one and single-byte values mixed in.
	function automatic logic [31:0] rand_pixel();
		case ($urandom_range(0, 7))
			0:       return 32'h0;
			1:       return 32'hffff_ffff;
			2:       return 32'hff << (8 * $urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	// Reset defaults copy pixels straight through, top byte included.
	task automatic test_reset_copy();
		send_pixel(32'h0000_0000);
		send_pixel(32'hffff_ffff);
		send_pixel(32'h1234_5678);
	endtask

	// Raw three-byte packing; the unused top byte ORs into the next word.
	task automatic test_raw_pack24();
		apply_config(5'd0, 5'd3, 5'd8, 5'd16, 5'd8, 5'd8, 5'd8, 5'd0);
		send_pixel(32'hffff_ffff);
		send_pixel(32'h0102_0304);
		send_pixel(32'h0000_0000);
		send_pixel(32'ha5a5_a5a5);
	endtask

	// Converted two-byte packing in the usual 5-6-5 layout.
	task automatic test_rgb565_pack16();
		apply_config(5'd1, 5'd2, 5'd5, 5'd11, 5'd6, 5'd5, 5'd5, 5'd0);
		send_pixel(32'hffff_ffff);
		send_pixel(32'h00ff_00ff);
		send_pixel(32'h8080_8080);
		send_pixel(32'h0000_0000);
	endtask

	// Widths above eight, widths of zero, top positions and the 16-bit trim.
	task automatic test_wide_fields();
		apply_config(5'd1, 5'd4, 5'd15, 5'd31, 5'd15, 5'd31, 5'd15, 5'd31);
		send_pixel(32'hffff_ffff);
		send_pixel(32'h0001_0101);
		apply_config(5'd1, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
		send_pixel(32'hffff_ffff);
		apply_config(5'd1, 5'd3, 5'd15, 5'd20, 5'd12, 5'd9, 5'd9, 5'd3);
		repeat (4) send_pixel($urandom);
		// Any format code other than 3 and 4 falls back to two-byte packing.
		apply_config(5'd1, 5'd7, 5'd8, 5'd24, 5'd8, 5'd12, 5'd8, 5'd4);
		send_pixel(32'hffff_ffff);
		send_pixel(32'h00c3_5a96);
	endtask

	// A register write drops a half-built group; format 0 still packs three-byte raw.
	task automatic test_group_drop();
		apply_config(5'd0, 5'd3, 5'd8, 5'd16, 5'd8, 5'd8, 5'd8, 5'd0);
		send_pixel(32'hdead_beef);
		send_pixel(32'hcafe_f00d);
		apply_config(5'd0, 5'd0, 5'd8, 5'd16, 5'd8, 5'd8, 5'd8, 5'd0);
		repeat (4) send_pixel($urandom);
	endtask

	// Random phases, each with its own register settings and idle behavior.
	task automatic test_random();
		int sent;
		int len;
		int kind;
		logic [2:0] bpp_val;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			kind = $urandom_range(0, 7);
			if (kind == 0) begin
				// All registers at their top code.
				apply_config('1, '1, '1, '1, '1, '1, '1, '1);
			end else if (kind == 1) begin
				apply_config('0, '0, '0, '0, '0, '0, '0, '0);
			end else begin
				bpp_val = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
					: 3'($urandom_range(2, 4));
				apply_config(CFG_W'($urandom), {2'($urandom_range(0, 3)), bpp_val},
					rand_bits_word(), CFG_W'($urandom), rand_bits_word(), CFG_W'($urandom),
					rand_bits_word(), CFG_W'($urandom));
			end
			no_idle = ($urandom_range(0, 3) == 0);
			len = $urandom_range(20, 80);
			repeat (len) send_pixel(rand_pixel());
			sent += len;
		end
		no_idle = 1'b0;
	endtask

	// Compare every accepted word with the oldest expected one.
	always @(posedge clk) begin : check_words
		logic [31:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$error("out_word: expected none, got %h", out_word);
				mismatch_count++;
			end else begin
				want = expected_words.pop_front();
				if (out_word !== want) begin
					$error("out_word: expected %h, got %h", want, out_word);
					mismatch_count++;
				end
			end
		end
	end

	// Stall the output side by a random draw before each word, unless no_idle is set.
	initial begin : drive_out_ready
		int stall;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Hang detector: count cycles in which neither side moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		// Known values on every input from time zero.
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_addr       = '0;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		source_pixel   = '0;
		mismatch_count = 0;
		idle_cycles    = 0;
		no_idle        = 1'b0;

		// Predictor starts from the reset register values.
		cfg_convert    = 1'b0;
		cfg_bpp        = 3'd4;
		cfg_red_bits   = 4'd8;
		cfg_red_pos    = 5'd16;
		cfg_green_bits = 4'd8;
		cfg_green_pos  = 5'd8;
		cfg_blue_bits  = 4'd8;
		cfg_blue_pos   = 5'd0;
		group_phase    = 2'd0;
		carry_bits     = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_copy();
		test_raw_pack24();
		test_rgb565_pack16();
		test_wide_fields();
		test_group_drop();
		test_random();

		// Drain: wait out every owed word, then wait longer for strays.
		settle();
		repeat (2 * FLUSH_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_words.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
